[src/vzd_pkg.sv]
// Shared types and constants for the varint zigzag delta decoder.
package vzd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned WideW   = 64;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned UserW   = 8;

  // Last byte slot of a ten-byte varint.
  localparam logic [PosW-1:0] LastPos = 4'd9;
  localparam logic [WideW-1:0] PlainCap = 64'h0000_0000_0000_FFFF;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_OVERLONG  = 3'd1,
    ST_ABOVE     = 3'd2,
    ST_NEGATIVE  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_COUNT     = 3'd5
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECODE_MODE    = 8'd0,
    CFG_EXPECTED_COUNT = 8'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              has_value;
    status_t           status;
    logic              end_of_stream;
  } result_t;

endpackage

[src/vzd_step.sv]
// Per-byte decode logic and the stream state it updates.
module vzd_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [vzd_pkg::ByteW-1:0]    data_byte,
  input  logic                         last_byte,
  input  logic                         decode_mode,
  input  logic [vzd_pkg::CountW-1:0]   expected_count,
  output logic                         emit,
  output vzd_pkg::result_t             result
);

  logic [vzd_pkg::WideW-1:0]  partial_value, partial_value_next;
  logic [vzd_pkg::PosW-1:0]   byte_position, byte_position_next;
  logic [vzd_pkg::WideW-1:0]  running_sum, running_sum_next;
  logic [vzd_pkg::CountW-1:0] values_seen, values_seen_next;
  logic                       error_latched, error_latched_next;

  logic [6:0]                  payload;
  logic [6:0]                  shamt;
  logic [vzd_pkg::WideW-1:0]   merged;
  logic [vzd_pkg::WideW-1:0]   zz;
  logic [vzd_pkg::WideW-1:0]   sum;
  logic                        err;
  logic                        tenth;

  assign payload = data_byte[6:0];
  assign tenth   = (byte_position >= vzd_pkg::LastPos);
  // pos * 7; only used for pos 0..8, so it stays within 56
  assign shamt   = {byte_position, 3'b000} - {3'b000, byte_position};
  assign merged  = tenth ? (partial_value | {payload[0], 63'd0})
                         : (partial_value | ({57'd0, payload} << shamt[5:0]));
  assign zz      = {1'b0, merged[63:1]} ^ {vzd_pkg::WideW{merged[0]}};
  assign sum     = running_sum + zz;

  always_comb begin
    partial_value_next = partial_value;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    values_seen_next   = values_seen;
    error_latched_next = error_latched;
    emit               = 1'b0;
    err                = 1'b0;
    result.value         = '0;
    result.has_value     = 1'b0;
    result.status        = vzd_pkg::ST_OK;
    result.end_of_stream = last_byte;

    if (error_latched) begin
      // drop bytes until the stream closes; the error was already reported
      emit = last_byte;
    end else begin
      partial_value_next = merged;
      if (data_byte[7]) begin
        if (tenth) begin
          result.status = vzd_pkg::ST_OVERLONG;
          err  = 1'b1;
          emit = 1'b1;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end else begin
        partial_value_next = '0;
        byte_position_next = '0;
        emit = 1'b1;
        if (values_seen == expected_count) begin
          result.status = vzd_pkg::ST_COUNT;
          err = 1'b1;
        end else if (!decode_mode) begin
          if (sum[63]) begin
            result.status = vzd_pkg::ST_NEGATIVE;
            err = 1'b1;
          end else begin
            running_sum_next = sum;
            result.value     = sum[vzd_pkg::ValueW-1:0];
            result.has_value = 1'b1;
          end
        end else begin
          if (merged > vzd_pkg::PlainCap) begin
            result.status = vzd_pkg::ST_ABOVE;
            err = 1'b1;
          end else begin
            result.value     = merged[vzd_pkg::ValueW-1:0];
            result.has_value = 1'b1;
          end
        end
        if (!err) begin
          values_seen_next = values_seen + 32'd1;
        end
      end
      if (err) begin
        error_latched_next = 1'b1;
      end
      if (last_byte) begin
        emit = 1'b1;
        if (!err) begin
          if (byte_position_next != '0) begin
            result.status = vzd_pkg::ST_TRUNCATED;
          end else if (values_seen_next != expected_count) begin
            result.status = vzd_pkg::ST_COUNT;
          end
        end
      end
    end

    if (last_byte) begin
      partial_value_next = '0;
      byte_position_next = '0;
      running_sum_next   = '0;
      values_seen_next   = '0;
      error_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      byte_position <= '0;
      running_sum   <= '0;
      values_seen   <= '0;
      error_latched <= 1'b0;
    end else if (fire) begin
      partial_value <= partial_value_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      values_seen   <= values_seen_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

[src/vzd_out_reg.sv]
// Result register driving the master-side stream.
module vzd_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  vzd_pkg::result_t      result,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [vzd_pkg::ValueW-1:0] m_tdata,
  output logic [vzd_pkg::UserW-1:0]  m_tuser,
  output logic                  m_tlast
);

  logic             valid;
  vzd_pkg::result_t held;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = held.value;
  assign m_tuser  = {4'd0, held.status, held.has_value};
  assign m_tlast  = held.end_of_stream;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

[src/varint_zigzag_delta_decoder.sv]
// Top level of the varint zigzag delta decoder.
//
// Slave stream: one byte of an inflated varint stream per item; tlast marks
// the final byte of the stream. Master stream: zero or one result per byte,
// carrying the decoded value in tdata, {status, has_value} in tuser and the
// end-of-stream flag in tlast. A result appears for a completed varint, an
// error, or the closing byte; other bytes produce nothing downstream.
// Config channel: index 0 writes decode_mode (bit 0), index 1 writes
// expected_count; other indexes are dropped. It is always ready and should
// only be written while no stream is in flight.
//
// An accepted byte is held in the input register, then its result is loaded
// into the output register, which drives m_tvalid. Throughput is one byte per
// cycle unless a byte that yields a result must wait on a stalled receiver;
// the longest path is the varint merge into the 64-bit add.
// Reset clears stream state, config registers and both valid flags.
// When the receiver stalls, the result holds; the input register keeps
// taking bytes that give no result and stops only when one must wait.
module varint_zigzag_delta_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [vzd_pkg::ByteW-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,   // last_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vzd_pkg::ValueW-1:0]    m_tdata,   // [31:0] value
  output logic [vzd_pkg::UserW-1:0]     m_tuser,   // [0] has_value, [3:1] status, rest 0
  output logic                          m_tlast,   // end_of_stream
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vzd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vzd_pkg::CfgDataW-1:0]  cfg_data
);

  // config registers
  logic                        decode_mode;
  logic [vzd_pkg::CountW-1:0]  expected_count;

  // input register
  logic                        in_valid;
  logic [vzd_pkg::ByteW-1:0]   in_byte;
  logic                        in_last;

  logic             emit;
  logic             out_free;
  logic             advance;
  vzd_pkg::result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode    <= 1'b0;
      expected_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vzd_pkg::CFG_DECODE_MODE:    decode_mode    <= cfg_data[0];
        vzd_pkg::CFG_EXPECTED_COUNT: expected_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // A byte that yields no result never waits on the output side.
  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  vzd_step u_step (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .data_byte      (in_byte),
    .last_byte      (in_last),
    .decode_mode    (decode_mode),
    .expected_count (expected_count),
    .emit           (emit),
    .result         (result)
  );

  vzd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[src/vzd_checker.sv]
// Port-level checks for the decoder, bound to the top level.
module vzd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [vzd_pkg::ValueW-1:0]    m_tdata,
  input logic [vzd_pkg::UserW-1:0]     m_tuser,
  input logic                          m_tlast
);

  // output stays idle right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // a result without a value carries a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("value nonzero without has_value");

  // value errors never carry a value
  a_err_no_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[3:1] == vzd_pkg::ST_OVERLONG ||
                 m_tuser[3:1] == vzd_pkg::ST_ABOVE ||
                 m_tuser[3:1] == vzd_pkg::ST_NEGATIVE ||
                 m_tuser[3:1] == vzd_pkg::ST_TRUNCATED) |-> !m_tuser[0])
    else $error("error status with has_value");

  // truncation is only reported on the closing byte
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:1] == vzd_pkg::ST_TRUNCATED |-> m_tlast)
    else $error("truncated status before end of stream");

endmodule

bind varint_zigzag_delta_decoder vzd_checker u_vzd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[dv/tb_top.sv]
// Testbench for the varint zigzag delta decoder: directed, stall and random byte streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TailCycles          = 6;
  localparam int WatchdogLimit       = 2000; // well above the longest receiver hold
  localparam int LongHold            = 300;
  localparam int RandomBytesPerPhase = 500;
  localparam int MaxPrinted          = 40;

  // indexes past the register list; the block must drop these writes
  localparam logic [vzd_pkg::CfgIdxW-1:0] CfgIdxPastEnd = 8'd2;
  localparam logic [vzd_pkg::CfgIdxW-1:0] CfgIdxTop     = 8'hFF;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [vzd_pkg::ByteW-1:0]    s_tdata   = '0;
  logic                         s_tlast   = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [vzd_pkg::ValueW-1:0]   m_tdata;
  logic [vzd_pkg::UserW-1:0]    m_tuser;   // [0] has_value, [3:1] status
  logic                         m_tlast;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [vzd_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [vzd_pkg::CfgDataW-1:0] cfg_data  = '0;

  varint_zigzag_delta_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder state as the testbench tracks it, updated on every accepted byte.
  // ---------------------------------------------------------------------------
  logic                        cur_mode   = 1'b0;
  logic [vzd_pkg::CountW-1:0]  cur_count  = '0;
  logic [vzd_pkg::WideW-1:0]   acc_bits   = '0;   // varint being assembled
  logic [vzd_pkg::PosW-1:0]    acc_pos    = '0;   // byte slot of the next varint byte
  logic [vzd_pkg::WideW-1:0]   delta_sum  = '0;   // running sum, two's complement
  logic [vzd_pkg::CountW-1:0]  values_done = '0;
  logic                        stream_faulted = 1'b0;

  vzd_pkg::result_t awaited_results[$];

  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;

  // Append one awaited result at the tail of the queue.
  function automatic void queue_result(input vzd_pkg::result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic void restart_stream();
    acc_bits       = '0;
    acc_pos        = '0;
    delta_sum      = '0;
    values_done    = '0;
    stream_faulted = 1'b0;
  endfunction

  // Work out the result, if any, that one accepted byte causes.
  task automatic track_decode(input logic [vzd_pkg::ByteW-1:0] b, input logic close);
    vzd_pkg::result_t          r;
    logic [vzd_pkg::WideW-1:0] u;
    logic [vzd_pkg::WideW-1:0] s;
    logic                      emit;
    logic                      fault;
    r     = '0;
    emit  = 1'b0;
    fault = 1'b0;
    if (stream_faulted) begin
      // error already reported: swallow bytes up to the stream end
      if (close) begin
        r.status        = vzd_pkg::ST_OK;
        r.end_of_stream = 1'b1;
        queue_result(r);
        restart_stream();
      end
    end else begin
      // byte ten only carries bit 63; the rest of its payload falls off
      if (acc_pos >= vzd_pkg::LastPos) begin
        acc_bits[vzd_pkg::WideW-1] = acc_bits[vzd_pkg::WideW-1] | b[0];
      end else begin
        acc_bits = acc_bits | ({{(vzd_pkg::WideW-7){1'b0}}, b[6:0]} << (7 * acc_pos));
      end
      if (b[7]) begin
        if (acc_pos >= vzd_pkg::LastPos) begin
          r.status = vzd_pkg::ST_OVERLONG;
          fault    = 1'b1;
          emit     = 1'b1;
        end else begin
          acc_pos = acc_pos + 4'd1;
        end
      end else begin
        u        = acc_bits;
        acc_bits = '0;
        acc_pos  = '0;
        emit     = 1'b1;
        if (values_done == cur_count) begin
          r.status = vzd_pkg::ST_COUNT;   // value beyond the configured count
          fault    = 1'b1;
        end else if (cur_mode == 1'b0) begin
          s = delta_sum + ((u >> 1) ^ {vzd_pkg::WideW{u[0]}});
          if (s[vzd_pkg::WideW-1]) begin
            r.status = vzd_pkg::ST_NEGATIVE;
            fault    = 1'b1;
          end else begin
            delta_sum   = s;
            r.value     = s[vzd_pkg::ValueW-1:0];
            r.has_value = 1'b1;
          end
        end else begin
          if (u > vzd_pkg::PlainCap) begin
            r.status = vzd_pkg::ST_ABOVE;
            fault    = 1'b1;
          end else begin
            r.value     = u[vzd_pkg::ValueW-1:0];
            r.has_value = 1'b1;
          end
        end
        if (!fault) values_done = values_done + 32'd1;
      end
      if (fault) stream_faulted = 1'b1;
      if (close) begin
        emit            = 1'b1;
        r.end_of_stream = 1'b1;
        if (!fault) begin
          if (acc_pos != '0) r.status = vzd_pkg::ST_TRUNCATED;
          else if (values_done != cur_count) r.status = vzd_pkg::ST_COUNT;
        end
      end
      if (emit) queue_result(r);
      if (close) restart_stream();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and watchdog, sampled at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input logic [vzd_pkg::WideW-1:0] got,
                               input logic [vzd_pkg::WideW-1:0] want);
    if (mismatches < MaxPrinted) begin
      $display("%0t ns: result %0d %s mismatch: got %0h, want %0h",
               $time, results_seen, field, got, want);
    end
    mismatches++;
  endtask

  task automatic check_result();
    vzd_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch("unexpected item", {32'd0, m_tdata}, '0);
    end else begin
      want = awaited_results.pop_front();
      if (m_tdata !== want.value) begin
        note_mismatch("value", {32'd0, m_tdata}, {32'd0, want.value});
      end
      if (m_tuser[0] !== want.has_value) begin
        note_mismatch("has_value", {63'd0, m_tuser[0]}, {63'd0, want.has_value});
      end
      if (m_tuser[3:1] !== want.status) begin
        note_mismatch("status", {61'd0, m_tuser[3:1]}, {61'd0, want.status});
      end
      if (m_tlast !== want.end_of_stream) begin
        note_mismatch("end_of_stream", {63'd0, m_tlast}, {63'd0, want.end_of_stream});
      end
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_result();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold when a test asks for one.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [vzd_pkg::ByteW-1:0] b, input logic close);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= close;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_decode(b, close);
    bytes_sent++;
    @(negedge clk);
  endtask

  // LEB128 with optional zero padding groups; close marks the final byte.
  task automatic send_varint(input logic [vzd_pkg::WideW-1:0] v, input int pad,
                             input logic close);
    int                        len;
    int                        i;
    logic [vzd_pkg::WideW-1:0] rest;
    logic [6:0]                chunk;
    len  = 1;
    rest = v >> 7;
    while (rest != '0) begin
      len++;
      rest = rest >> 7;
    end
    len = (len + pad > 10) ? 10 : len + pad;
    for (i = 0; i < len; i++) begin
      rest  = v >> (7 * i);
      chunk = rest[6:0];
      if (i == 9) chunk[6:1] = 6'($urandom_range(63));   // junk above bit 63
      send_byte({(i < len - 1), chunk}, close && (i == len - 1));
    end
  endtask

  // Hold the sender until every awaited result is in and the pipe is empty.
  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra edge.
  task automatic write_register(input logic [vzd_pkg::CfgIdxW-1:0] idx,
                                input logic [vzd_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == vzd_pkg::CFG_DECODE_MODE) cur_mode = data[0];
    else if (idx == vzd_pkg::CFG_EXPECTED_COUNT) cur_count = data;
    @(negedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [vzd_pkg::CountW-1:0] count);
    logic [vzd_pkg::CfgDataW-1:0] word;
    word    = $urandom;   // upper bits of the mode word must be ignored
    word[0] = mode;
    write_register(vzd_pkg::CFG_DECODE_MODE, word);
    write_register(vzd_pkg::CFG_EXPECTED_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random stream content.
  // ---------------------------------------------------------------------------
  function automatic logic [vzd_pkg::WideW-1:0] zz_pack(
      input logic signed [vzd_pkg::WideW-1:0] d);
    return (d << 1) ^ {vzd_pkg::WideW{d[vzd_pkg::WideW-1]}};
  endfunction

  // Delta code for mode 0; negative deltas always keep the sum at or above zero.
  function automatic logic [vzd_pkg::WideW-1:0] pick_delta_code();
    int                        nbits;
    logic [vzd_pkg::WideW-1:0] mag;
    nbits = ($urandom_range(99) < 85) ? 7 * $urandom_range(1, 3) : $urandom_range(22, 62);
    mag   = {$urandom, $urandom} & ((64'd1 << nbits) - 64'd1);
    if ($urandom_range(99) < 35 && mag != '0 && mag <= delta_sum) return zz_pack(-mag);
    return zz_pack(mag);
  endfunction

  function automatic logic [vzd_pkg::WideW-1:0] pick_plain();
    int r;
    r = $urandom_range(99);
    if (r < 10) return vzd_pkg::PlainCap;
    if (r < 40) return {32'd0, $urandom_range(0, 127)};
    return {32'd0, $urandom_range(0, 65535)};
  endfunction

  function automatic logic [vzd_pkg::CountW-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 9) return '1;
    if (r < 12) return $urandom;
    return $urandom_range(1, 12);
  endfunction

  task automatic inject_fault();
    int         i;
    logic [6:0] junk;
    case ($urandom_range(2))
      0: begin
        // ten bytes all asking for more
        for (i = 0; i < 10; i++) begin
          junk = 7'($urandom);
          send_byte({1'b1, junk}, 1'b0);
        end
      end
      1: send_varint(cur_mode ? 64'd65536 + {32'd0, $urandom_range(0, 1000)}
                              : zz_pack(-(delta_sum + 64'd1)),
                     0, 1'b0);
      default: send_varint({$urandom, $urandom}, 0, 1'b0);
    endcase
  endtask

  // One stream, mostly well formed, ending on a byte with tlast.
  task automatic random_stream();
    int                        n;
    int                        total;
    int                        i;
    int                        shape;
    int                        cut;
    logic                      trunc;
    logic                      faulty;
    logic [6:0]                junk;
    logic [vzd_pkg::WideW-1:0] code;
    if ($urandom_range(99) < 25) begin
      wait_until_idle();
      set_config(1'($urandom_range(1)), pick_count());
    end
    n     = (cur_count > 12) ? $urandom_range(0, 6) : int'(cur_count);
    shape = $urandom_range(99);
    if (shape < 6) n = n + 1;                 // one value too many
    else if (shape < 12 && n > 0) n = n - 1;  // one value short
    trunc  = (shape >= 80 && shape < 88);
    faulty = (shape >= 88 && shape < 92);
    if (shape >= 92) begin
      // raw noise
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end else begin
      total = (n == 0 && !trunc) ? 1 : n;
      cut   = (total > 1 && $urandom_range(99) < 5) ? $urandom_range(1, total - 1) : -1;
      for (i = 0; i < total; i++) begin
        if (i == cut) wait_until_idle();   // pause mid-stream until drained
        if (faulty && i == total / 2) inject_fault();
        code = cur_mode ? pick_plain() : pick_delta_code();
        send_varint(code, ($urandom_range(99) < 5) ? $urandom_range(1, 3) : 0,
                    !trunc && i == total - 1);
      end
      if (trunc) begin
        junk = 7'($urandom);
        send_byte({1'b1, junk}, 1'b1);   // stream ends inside a varint
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_delta_basics();
    write_register(CfgIdxPastEnd, '1);
    write_register(CfgIdxTop, '0);
    set_config(1'b0, 32'd2);
    send_byte(8'h02, 1'b0);   // +1
    send_byte(8'h01, 1'b1);   // -1, back to zero, clean close
  endtask

  task automatic test_tenth_byte();
    wait_until_idle();
    set_config(1'b1, 32'd1);
    repeat (9) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);   // only bit 0 lands: all ones, above cap
    wait_until_idle();
    set_config(1'b0, 32'd1);
    repeat (9) send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);   // continuation on byte ten, with stream end
  endtask

  task automatic test_stream_errors();
    wait_until_idle();
    set_config(1'b1, '1);
    send_byte(8'h00, 1'b1);   // count short, value still shown
    wait_until_idle();
    set_config(1'b0, '0);
    send_byte(8'h05, 1'b0);   // value beyond a count of zero
    send_byte(8'h7F, 1'b0);   // swallowed after the error
    send_byte(8'h00, 1'b1);   // quiet close
    wait_until_idle();
    set_config(1'b0, 32'd3);
    send_byte(8'h01, 1'b1);   // -1 from zero on the closing byte
    send_byte(8'h80, 1'b1);   // stream ends inside a varint
  endtask

  // Receiver holds off while bytes keep coming, then the sender drains mid-stream.
  task automatic test_backpressure();
    int i;
    wait_until_idle();
    set_config(1'b1, 32'd40);
    @(posedge clk);
    hold_request = LongHold;
    @(negedge clk);
    for (i = 0; i < 40; i++) begin
      if (i == 20) wait_until_idle();
      send_byte(8'($urandom_range(0, 127)), i == 39);
    end
  endtask

  task automatic test_random_streams(input int snd_pct, input int rcv_pct);
    int start;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytesPerPhase) random_stream();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_delta_basics();
    test_tenth_byte();
    test_stream_errors();
    test_backpressure();
    test_random_streams(26, 50);
    test_random_streams(50, 26);
    test_random_streams(0, 0);
    wait_until_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
